>>> src/lbp_r2_p8_histogram_core_macros.svh
// Assertion macros shared by the histogram core.
`ifndef LBP_R2_P8_HISTOGRAM_CORE_MACROS_SVH
`define LBP_R2_P8_HISTOGRAM_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LBPH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed in %m");

// Next-cycle implication, checked outside reset.
`define LBPH_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed in %m");

`endif

>>> src/lbph_pkg.sv
package lbph_pkg;

  localparam int unsigned MAX_COLUMNS_DEF = 1024;
  localparam int unsigned MAX_ROWS_DEF    = 1024;
  localparam int unsigned PIXEL_BITS_DEF  = 8;

  localparam int unsigned CFG_W   = 11;
  localparam int unsigned IN_PX_W = 8;
  localparam int unsigned BIN_W   = 8;
  localparam int unsigned BINS    = 256;
  localparam int unsigned COUNT_W = 20;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam int unsigned CFG_FRAME_COLUMNS = 0;
  localparam int unsigned CFG_FRAME_ROWS    = 1;
  localparam logic [CFG_W-1:0] SIZE_RESET = 11'd1024;

  localparam int unsigned MID_DEPTH = 8;
  localparam int unsigned OUT_DEPTH = 4;

  localparam logic [15:0] W_NEAR    = 16'd22046;
  localparam logic [15:0] W_ROWMATE = 16'd15584;
  localparam logic [15:0] W_COLMATE = 16'd15965;
  localparam logic [15:0] W_FAR     = 16'd11285;

  typedef enum logic [1:0] {
    OP_COUNT = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [BIN_W-1:0] bin;
  } op_t;

  typedef struct packed {
    logic [BIN_W-1:0]   bin;
    logic [COUNT_W-1:0] count;
  } res_t;

endpackage

>>> src/lbp_r2_p8_histogram_core.sv
// Radius-2, eight-point local binary pattern histogram. Pixel requests arrive in
// raster order; each full 5x5 window inside the frame adds one to the bin of its
// pattern code, and the histogram restarts at each frame's first pixel. A read
// request returns one bin's count for the current frame. The core takes one
// request per clock while full is low: the line stores do one read and one
// write per cycle and the histogram memory does one read-modify-write per cycle,
// with forwarding between back-to-back requests. A read result reaches the result
// ports through the request queue and the result queue. Full rises only when
// results are not popped and the internal request queue between the window
// logic and the histogram fills.
module lbp_r2_p8_histogram_core #(
  parameter int unsigned MAX_COLUMNS = lbph_pkg::MAX_COLUMNS_DEF,
  parameter int unsigned MAX_ROWS    = lbph_pkg::MAX_ROWS_DEF,
  parameter int unsigned PIXEL_BITS  = lbph_pkg::PIXEL_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic                               cfg_index_i,
  input  logic [lbph_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic                               push,
  output logic                               full,
  input  logic                               req_type_i,
  input  logic [lbph_pkg::IN_PX_W-1:0]       pixel_value_i,
  input  logic [lbph_pkg::BIN_W-1:0]         bin_select_i,
  output logic                               empty,
  input  logic                               pop,
  output logic [lbph_pkg::BIN_W-1:0]         bin_echo_o,
  output logic [lbph_pkg::COUNT_W-1:0]       bin_count_o
);

  `include "lbp_r2_p8_histogram_core_macros.svh"

  localparam int unsigned MCW = $clog2(lbph_pkg::MID_DEPTH + 1);
  localparam int unsigned OCW = $clog2(lbph_pkg::OUT_DEPTH + 1);

  logic [lbph_pkg::CFG_W-1:0] frame_columns_q, frame_rows_q;
  logic                       accept, in1, in2;
  logic                       op_push, op_pop, op_empty, res_push;
  lbph_pkg::op_t              op_in, op_out;
  lbph_pkg::res_t             res_in, res_out;
  logic [MCW-1:0]             mid_cnt;
  logic [OCW-1:0]             out_cnt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_columns_q <= lbph_pkg::SIZE_RESET;
      frame_rows_q    <= lbph_pkg::SIZE_RESET;
    end else if (cfg_we_i) begin
      if (cfg_index_i == 1'(lbph_pkg::CFG_FRAME_COLUMNS)) begin
        frame_columns_q <= cfg_data_i;
      end else begin
        frame_rows_q <= cfg_data_i;
      end
    end
  end

  assign full   = ((MCW + 1)'(mid_cnt) + (MCW + 1)'(in1) + (MCW + 1)'(in2))
                  >= (MCW + 1)'(lbph_pkg::MID_DEPTH);
  assign accept = push && !full;

  lbph_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .PIXEL_BITS  (PIXEL_BITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .frame_columns_i (frame_columns_q),
    .frame_rows_i    (frame_rows_q),
    .accept_i        (accept),
    .req_type_i      (req_type_i),
    .pixel_value_i   (pixel_value_i),
    .bin_select_i    (bin_select_i),
    .inflight1_o     (in1),
    .inflight2_o     (in2),
    .op_push_o       (op_push),
    .op_o            (op_in)
  );

  lbph_fifo #(
    .WIDTH ($bits(lbph_pkg::op_t)),
    .DEPTH (lbph_pkg::MID_DEPTH)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (op_push),
    .data_i  (op_in),
    .pop_i   (op_pop),
    .data_o  (op_out),
    .empty_o (op_empty),
    .count_o (mid_cnt)
  );

  lbph_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_empty_i  (op_empty),
    .op_i        (op_out),
    .op_pop_o    (op_pop),
    .res_count_i (out_cnt),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  lbph_fifo #(
    .WIDTH ($bits(lbph_pkg::res_t)),
    .DEPTH (lbph_pkg::OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty),
    .count_o (out_cnt)
  );

  assign bin_echo_o  = res_out.bin;
  assign bin_count_o = res_out.count;

  `LBPH_ASSERT_IMP(a_mid_no_overflow, clk_i, rst_ni, op_push, (32'(mid_cnt) < lbph_pkg::MID_DEPTH) || op_pop)
  `LBPH_ASSERT_IMP(a_out_no_overflow, clk_i, rst_ni, res_push, (32'(out_cnt) < lbph_pkg::OUT_DEPTH) || (pop && !empty))
  `LBPH_ASSERT_NXT(a_read_in_flight, clk_i, rst_ni, accept && req_type_i, in1)

endmodule

>>> src/lbph_fifo.sv
module lbph_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [WIDTH-1:0]             data_i,
  input  logic                         pop_i,
  output logic [WIDTH-1:0]             data_o,
  output logic                         empty_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign do_pop  = pop_i && (cnt_q != '0);
  assign do_push = push_i;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (32'(wr_q) == DEPTH - 1) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (32'(rd_q) == DEPTH - 1) ? '0 : rd_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_q];
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;

endmodule

>>> src/lbph_front.sv
module lbph_front #(
  parameter int unsigned MAX_COLUMNS = lbph_pkg::MAX_COLUMNS_DEF,
  parameter int unsigned MAX_ROWS    = lbph_pkg::MAX_ROWS_DEF,
  parameter int unsigned PIXEL_BITS  = lbph_pkg::PIXEL_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [lbph_pkg::CFG_W-1:0]       frame_columns_i,
  input  logic [lbph_pkg::CFG_W-1:0]       frame_rows_i,
  input  logic                             accept_i,
  input  logic                             req_type_i,
  input  logic [lbph_pkg::IN_PX_W-1:0]     pixel_value_i,
  input  logic [lbph_pkg::BIN_W-1:0]       bin_select_i,
  output logic                             inflight1_o,
  output logic                             inflight2_o,
  output logic                             op_push_o,
  output lbph_pkg::op_t                    op_o
);

  localparam int unsigned PB  = PIXEL_BITS;
  localparam int unsigned CLW = $clog2(MAX_COLUMNS);
  localparam int unsigned RLW = $clog2(MAX_ROWS);
  localparam int unsigned CSW = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned RSW = $clog2(MAX_ROWS + 1);
  localparam int unsigned SW  = PB + 18;

  function automatic logic diag_bit(input logic [PB-1:0] n, input logic [PB-1:0] r,
                                    input logic [PB-1:0] c, input logic [PB-1:0] f,
                                    input logic [PB-1:0] ctr);
    logic [SW-1:0] s;
    s = SW'(lbph_pkg::W_NEAR) * SW'(n) + SW'(lbph_pkg::W_ROWMATE) * SW'(r)
      + SW'(lbph_pkg::W_COLMATE) * SW'(c) + SW'(lbph_pkg::W_FAR) * SW'(f);
    return s >= SW'({ctr, 16'h0000});
  endfunction

  logic [CSW-1:0] ncols;
  logic [RSW-1:0] nrows;
  logic [CLW-1:0] col_q, col_d, col_eff;
  logic [RLW-1:0] row_q, row_d, row_eff;
  logic [CSW-1:0] col_inc;
  logic [RSW-1:0] row_inc;
  logic [PB-1:0]  px;
  logic           acc_px;

  logic [PB-1:0]  line_mem [4][MAX_COLUMNS];
  logic [PB-1:0]  rd_q [4];
  logic [PB-1:0]  byp_data_q [4];
  logic           byp_q;
  logic [PB-1:0]  eff [4];

  logic                        s1v_q, s1read_q, s1count_q, s1clear_q;
  logic [PB-1:0]               s1px_q;
  logic [CLW-1:0]              s1col_q;
  logic [lbph_pkg::BIN_W-1:0]  s1bin_q;
  logic                        s1wr;

  logic [PB-1:0]               win_q [5][5];
  logic                        s2v_q, s2read_q, s2count_q, s2clear_q;
  logic [lbph_pkg::BIN_W-1:0]  s2bin_q;
  logic [7:0]                  code;
  logic [PB-1:0]               ctr;

  always_comb begin
    if (frame_columns_i == '0) begin
      ncols = CSW'(1);
    end else if (32'(frame_columns_i) > MAX_COLUMNS) begin
      ncols = CSW'(MAX_COLUMNS);
    end else begin
      ncols = CSW'(frame_columns_i);
    end
    if (frame_rows_i == '0) begin
      nrows = RSW'(1);
    end else if (32'(frame_rows_i) > MAX_ROWS) begin
      nrows = RSW'(MAX_ROWS);
    end else begin
      nrows = RSW'(frame_rows_i);
    end
  end

  assign col_eff = (CSW'(col_q) >= ncols) ? '0 : col_q;
  assign row_eff = (RSW'(row_q) >= nrows) ? '0 : row_q;
  assign col_inc = CSW'(col_eff) + CSW'(1);
  assign row_inc = RSW'(row_eff) + RSW'(1);
  assign px      = PB'(pixel_value_i);
  assign acc_px  = accept_i && !req_type_i;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (acc_px) begin
      if (col_inc >= ncols) begin
        col_d = '0;
        row_d = (row_inc >= nrows) ? '0 : row_inc[RLW-1:0];
      end else begin
        col_d = col_inc[CLW-1:0];
        row_d = row_eff;
      end
    end
  end

  assign s1wr = s1v_q && !s1read_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      eff[i] = byp_q ? byp_data_q[i] : rd_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      rd_q[i] <= line_mem[i][col_eff];
    end
    if (s1wr) begin
      for (int i = 0; i < 3; i++) begin
        line_mem[i][s1col_q] <= eff[i+1];
      end
      line_mem[3][s1col_q] <= s1px_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      byp_data_q[i] <= eff[i+1];
    end
    byp_data_q[3] <= s1px_q;
    s1px_q  <= px;
    s1col_q <= col_eff;
    s1bin_q <= bin_select_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      byp_q     <= 1'b0;
      s1v_q     <= 1'b0;
      s1read_q  <= 1'b0;
      s1count_q <= 1'b0;
      s1clear_q <= 1'b0;
      s2v_q     <= 1'b0;
      s2read_q  <= 1'b0;
      s2count_q <= 1'b0;
      s2clear_q <= 1'b0;
      s2bin_q   <= '0;
      for (int i = 0; i < 5; i++) begin
        for (int j = 0; j < 5; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else begin
      col_q     <= col_d;
      row_q     <= row_d;
      byp_q     <= s1wr && (s1col_q == col_eff);
      s1v_q     <= accept_i;
      s1read_q  <= req_type_i;
      s1count_q <= (row_eff >= RLW'(4)) && (col_eff >= CLW'(4));
      s1clear_q <= (row_eff == '0) && (col_eff == '0);
      s2v_q     <= s1v_q;
      s2read_q  <= s1read_q;
      s2count_q <= s1count_q;
      s2clear_q <= s1clear_q;
      s2bin_q   <= s1bin_q;
      if (s1wr) begin
        for (int i = 0; i < 5; i++) begin
          for (int j = 0; j < 4; j++) begin
            win_q[i][j] <= win_q[i][j+1];
          end
        end
        for (int i = 0; i < 4; i++) begin
          win_q[i][4] <= eff[i];
        end
        win_q[4][4] <= s1px_q;
      end
    end
  end

  assign ctr = win_q[2][2];

  always_comb begin
    code[0] = diag_bit(win_q[1][1], win_q[1][0], win_q[0][1], win_q[0][0], ctr);
    code[1] = win_q[0][2] >= ctr;
    code[2] = diag_bit(win_q[1][3], win_q[1][4], win_q[0][3], win_q[0][4], ctr);
    code[3] = win_q[2][4] >= ctr;
    code[4] = diag_bit(win_q[3][3], win_q[3][4], win_q[4][3], win_q[4][4], ctr);
    code[5] = win_q[4][2] >= ctr;
    code[6] = diag_bit(win_q[3][1], win_q[3][0], win_q[4][1], win_q[4][0], ctr);
    code[7] = win_q[2][0] >= ctr;
  end

  always_comb begin
    op_push_o = 1'b0;
    op_o.op   = lbph_pkg::OP_READ;
    op_o.bin  = s2bin_q;
    if (s2v_q) begin
      if (s2read_q) begin
        op_push_o = 1'b1;
      end else if (s2clear_q) begin
        op_push_o = 1'b1;
        op_o.op   = lbph_pkg::OP_CLEAR;
      end else if (s2count_q) begin
        op_push_o = 1'b1;
        op_o.op   = lbph_pkg::OP_COUNT;
        op_o.bin  = code;
      end
    end
  end

  assign inflight1_o = s1v_q;
  assign inflight2_o = s2v_q;

endmodule

>>> src/lbph_back.sv
module lbph_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 op_empty_i,
  input  lbph_pkg::op_t                        op_i,
  output logic                                 op_pop_o,
  input  logic [$clog2(lbph_pkg::OUT_DEPTH+1)-1:0] res_count_i,
  output logic                                 res_push_o,
  output lbph_pkg::res_t                       res_o
);

  localparam int unsigned RCW = $clog2(lbph_pkg::OUT_DEPTH + 1) + 1;

  logic [lbph_pkg::COUNT_W-1:0] hist_mem [lbph_pkg::BINS];
  logic [lbph_pkg::BINS-1:0]    vld_q;

  logic                         bv_q;
  lbph_pkg::op_e                bop_q;
  logic [lbph_pkg::BIN_W-1:0]   bbin_q;
  logic [lbph_pkg::COUNT_W-1:0] rdata_q, fwdval_q, old_cnt, new_cnt;
  logic                         fwd_q, issue, bwr;

  assign issue    = !op_empty_i && ((RCW'(res_count_i) + RCW'(bv_q)) < RCW'(lbph_pkg::OUT_DEPTH));
  assign op_pop_o = issue;
  assign bwr      = bv_q && (bop_q == lbph_pkg::OP_COUNT);

  always_comb begin
    if (!vld_q[bbin_q]) begin
      old_cnt = '0;
    end else if (fwd_q) begin
      old_cnt = fwdval_q;
    end else begin
      old_cnt = rdata_q;
    end
    new_cnt = (old_cnt == lbph_pkg::COUNT_MAX) ? old_cnt : old_cnt + lbph_pkg::COUNT_W'(1);
  end

  always_ff @(posedge clk_i) begin
    rdata_q  <= hist_mem[op_i.bin];
    fwdval_q <= new_cnt;
    bop_q    <= op_i.op;
    bbin_q   <= op_i.bin;
    if (bwr) begin
      hist_mem[bbin_q] <= new_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bv_q  <= 1'b0;
      fwd_q <= 1'b0;
      vld_q <= '0;
    end else begin
      bv_q  <= issue;
      fwd_q <= bwr && (bbin_q == op_i.bin);
      if (bv_q) begin
        case (bop_q)
          lbph_pkg::OP_CLEAR: vld_q <= '0;
          lbph_pkg::OP_COUNT: vld_q[bbin_q] <= 1'b1;
          default: ;
        endcase
      end
    end
  end

  assign res_push_o = bv_q && (bop_q == lbph_pkg::OP_READ);
  assign res_o.bin   = bbin_q;
  assign res_o.count = old_cnt;

endmodule

>>> tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_READ  = 1'b1;
  localparam logic IDX_COLS  = 1'(lbph_pkg::CFG_FRAME_COLUMNS);
  localparam logic IDX_ROWS  = 1'(lbph_pkg::CFG_FRAME_ROWS);
  localparam int   LATENCY   = 16;
  localparam int   HOLD_LEN  = 300;

  typedef struct {
    logic [lbph_pkg::BIN_W-1:0]   bin;
    logic [lbph_pkg::COUNT_W-1:0] count;
  } bin_read_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_index_i = 1'b0;
  logic [lbph_pkg::CFG_W-1:0] cfg_data_i = '0;
  logic push = 1'b0;
  logic full;
  logic req_type_i = 1'b0;
  logic [lbph_pkg::IN_PX_W-1:0] pixel_value_i = '0;
  logic [lbph_pkg::BIN_W-1:0] bin_select_i = '0;
  logic empty;
  logic pop = 1'b0;
  logic [lbph_pkg::BIN_W-1:0] bin_echo_o;
  logic [lbph_pkg::COUNT_W-1:0] bin_count_o;

  lbp_r2_p8_histogram_core dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .push, .full, .req_type_i, .pixel_value_i, .bin_select_i,
    .empty, .pop, .bin_echo_o, .bin_count_o
  );

  // Predictor state.
  logic [lbph_pkg::CFG_W-1:0] cols_reg = lbph_pkg::SIZE_RESET;
  logic [lbph_pkg::CFG_W-1:0] rows_reg = lbph_pkg::SIZE_RESET;
  logic [7:0] line_mem [4][lbph_pkg::MAX_COLUMNS_DEF];
  logic [7:0] win [5][5];
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;
  int unsigned hist [lbph_pkg::BINS];

  bin_read_t expected_reads[$];
  int mismatches = 0;
  int reads_checked = 0;
  int pixels_sent = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic hold_req = 1'b0;
  int hold_cnt = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(20ns * 2000000);
    $display("lbp_r2_p8_histogram_core regression: fail");
    $finish;
  end

  function automatic int unsigned eff_size(logic [lbph_pkg::CFG_W-1:0] v, int unsigned lim);
    if (v == 0) return 1;
    if (32'(v) > lim) return lim;
    return 32'(v);
  endfunction

  function automatic logic diag_set(logic [7:0] n, logic [7:0] rm, logic [7:0] cm,
                                    logic [7:0] f, logic [7:0] c);
    longint unsigned s;
    s = longint'(lbph_pkg::W_NEAR) * n + longint'(lbph_pkg::W_ROWMATE) * rm +
        longint'(lbph_pkg::W_COLMATE) * cm + longint'(lbph_pkg::W_FAR) * f;
    return s >= (longint'(c) << 16);
  endfunction

  function automatic logic [7:0] window_code();
    logic [7:0] c;
    logic [7:0] code;
    c = win[2][2];
    code[0] = diag_set(win[1][1], win[1][0], win[0][1], win[0][0], c);
    code[1] = win[0][2] >= c;
    code[2] = diag_set(win[1][3], win[1][4], win[0][3], win[0][4], c);
    code[3] = win[2][4] >= c;
    code[4] = diag_set(win[3][3], win[3][4], win[4][3], win[4][4], c);
    code[5] = win[4][2] >= c;
    code[6] = diag_set(win[3][1], win[3][0], win[4][1], win[4][0], c);
    code[7] = win[2][0] >= c;
    return code;
  endfunction

  task automatic update_histogram(logic [7:0] px);
    int unsigned nc, nr, c, r;
    logic [7:0] code;
    nc = eff_size(cols_reg, lbph_pkg::MAX_COLUMNS_DEF);
    nr = eff_size(rows_reg, lbph_pkg::MAX_ROWS_DEF);
    c = (col_pos >= nc) ? 0 : col_pos;
    r = (row_pos >= nr) ? 0 : row_pos;
    if (r == 0 && c == 0) foreach (hist[b]) hist[b] = 0;
    for (int i = 0; i < 5; i++)
      for (int j = 0; j < 4; j++) win[i][j] = win[i][j+1];
    for (int i = 0; i < 4; i++) win[i][4] = line_mem[i][c];
    win[4][4] = px;
    for (int i = 0; i < 3; i++) line_mem[i][c] = line_mem[i+1][c];
    line_mem[3][c] = px;
    if (r >= 4 && c >= 4) begin
      code = window_code();
      if (hist[code] < 32'(lbph_pkg::COUNT_MAX)) hist[code]++;
    end
    c++;
    if (c >= nc) begin
      c = 0;
      r++;
      if (r >= nr) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endtask

  task automatic send_item(logic kind, logic [7:0] px, logic [7:0] bin);
    bin_read_t e;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    req_type_i <= kind;
    pixel_value_i <= px;
    bin_select_i <= bin;
    do @(posedge clk_i); while (full);
    if (kind == REQ_READ) begin
      e.bin = bin;
      e.count = 20'(hist[bin]);
      expected_reads.push_back(e);
    end else begin
      update_histogram(px);
      pixels_sent++;
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    while (expected_reads.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [lbph_pkg::CFG_W-1:0] val);
    drain();
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == IDX_COLS) cols_reg = val;
    else rows_reg = val;
  endtask

  task automatic set_size(logic [lbph_pkg::CFG_W-1:0] c, logic [lbph_pkg::CFG_W-1:0] r);
    write_reg(IDX_COLS, c);
    write_reg(IDX_ROWS, r);
  endtask

  function automatic logic [7:0] rand_pixel(int mode, logic [7:0] base);
    case (mode)
      0: return 8'($urandom_range(255));
      1: return base + 8'($urandom_range(3));
      default: return $urandom_range(1) ? 8'hFF : 8'h00;
    endcase
  endfunction

  // Sends one whole frame with reads of random bins scattered through it.
  task automatic send_frame(int read_pct);
    int unsigned n;
    int mode;
    logic [7:0] base;
    n = eff_size(cols_reg, lbph_pkg::MAX_COLUMNS_DEF) *
        eff_size(rows_reg, lbph_pkg::MAX_ROWS_DEF);
    mode = $urandom_range(2);
    base = 8'($urandom_range(255));
    for (int unsigned k = 0; k < n; k++) begin
      if ($urandom_range(99) < read_pct)
        send_item(REQ_READ, 8'($urandom), 8'($urandom));
      send_item(REQ_PIXEL, rand_pixel(mode, base), 8'($urandom));
    end
    repeat ($urandom_range(4, 1)) send_item(REQ_READ, 8'($urandom), 8'($urandom));
  endtask

  task automatic test_directed();
    set_size(11'd5, 11'd5);
    for (int k = 0; k < 25; k++) begin
      if (k == 12) send_item(REQ_READ, 8'h00, 8'hAA);
      send_item(REQ_PIXEL, (k % 3 == 0) ? 8'hFF : 8'h00, 8'hFF);
    end
    send_item(REQ_READ, 8'hFF, 8'h00);
    send_item(REQ_READ, 8'h00, 8'hFF);
    set_size(11'd0, 11'd0);
    repeat (3) send_item(REQ_PIXEL, 8'($urandom), 8'($urandom));
    send_item(REQ_READ, 8'h00, 8'h00);
  endtask

  task automatic test_random_frames(int sidle, int ridle, int quota);
    int start;
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    start = pixels_sent;
    while (pixels_sent - start < quota) begin
      set_size(11'($urandom_range(12, 5)), 11'($urandom_range(10, 5)));
      send_frame(25);
    end
  endtask

  task automatic test_size_extremes();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_size(11'd4, 11'd7);
    send_frame(10);
    set_size(11'd7, 11'd4);
    send_frame(10);
    set_size(11'd1024, 11'd1024);
    repeat (20) send_item(REQ_PIXEL, 8'($urandom), 8'($urandom));
    send_item(REQ_READ, 8'h00, 8'($urandom));
    set_size(11'd2047, 11'd5);
    repeat (40) send_item(REQ_PIXEL, 8'($urandom), 8'($urandom));
    send_item(REQ_READ, 8'h00, 8'($urandom));
    set_size(11'd5, 11'd2047);
    repeat (40) send_item(REQ_PIXEL, 8'($urandom), 8'($urandom));
    for (int b = 0; b < 4; b++) send_item(REQ_READ, 8'h00, 8'($urandom));
    drain();
    set_size(11'd5, 11'd5);
    send_frame(0);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    set_size(11'd6, 11'd6);
    send_frame(0);
    hold_req = 1'b1;
    repeat (60) send_item(REQ_READ, 8'($urandom), 8'($urandom));
    drain();
    hold_req = 1'b0;
  endtask

  // Result side: check each popped result and pick the next pop value.
  initial begin
    bin_read_t e;
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        if (expected_reads.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: bin %0d count %0d", bin_echo_o, bin_count_o);
        end else begin
          e = expected_reads.pop_front();
          reads_checked++;
          if (bin_echo_o !== e.bin || bin_count_o !== e.count) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected bin %0d count %0d, got bin %0d count %0d",
                       e.bin, e.count, bin_echo_o, bin_count_o);
          end
        end
      end
      if (hold_req && hold_cnt < HOLD_LEN) begin
        hold_cnt++;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    int waited;
    foreach (line_mem[i, j]) line_mem[i][j] = '0;
    foreach (win[i, j]) win[i][j] = '0;
    foreach (hist[b]) hist[b] = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_frames(33, 68, 50);
    test_random_frames(68, 33, 50);
    test_random_frames(0, 0, 50);
    test_size_extremes();
    test_backpressure();
    push <= 1'b0;
    waited = 0;
    while (expected_reads.size() != 0 && waited < 100000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (LATENCY) @(posedge clk_i);
    if (expected_reads.size() != 0) mismatches += expected_reads.size();
    $display("Sent %0d pixels over frame sizes from 1x1 up to the clamped limits, checked %0d bin reads.",
             pixels_sent, reads_checked);
    $display("Idle mixes on both sides and a long result stall were exercised.");
    if (mismatches == 0) begin
      $display("lbp_r2_p8_histogram_core regression: pass");
    end else begin
      $display("lbp_r2_p8_histogram_core regression: fail");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/lbph_pkg.sv
src/lbph_fifo.sv
src/lbph_front.sv
src/lbph_back.sv
src/lbp_r2_p8_histogram_core.sv
tb/tb.sv
